// ===== design/md5_pkg.sv =====
`default_nettype none

package md5_pkg;

   typedef struct packed {
      logic       req_type;
      logic [7:0] data_byte;
   } md5_req_type;

   typedef struct packed {
      logic [63:0] digest_second_half;
      logic [63:0] digest_first_half;
   } md5_rsp_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
   } md5_words_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_PREFETCH,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT
   } md5_state_type;

   // request kinds
   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_END  = 1'b1;

   localparam md5_words_type CHAIN_INIT = '{
      a: 32'h67452301,
      b: 32'hefcdab89,
      c: 32'h98badcfe,
      d: 32'h10325476
   };

   localparam logic [7:0] PAD_MARK    = 8'h80;
   localparam logic [5:0] LEN_POS     = 6'd56;
   localparam logic [5:0] LAST_BYTE   = 6'd63;
   localparam logic [5:0] LAST_ROUND  = 6'd63;
   localparam logic [3:0] LAST_WORD   = 4'd15;

   localparam logic [31:0] ROUND_CONST [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam logic [4:0] ROT_AMOUNT [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   // message word used by round r
   function automatic logic [3:0] word_index(input logic [5:0] r);
      logic [3:0] idx;
      idx = r[3:0];
      case (r[5:4])
         2'd0: idx = r[3:0];
         2'd1: idx = 4'(4'd5 * r[3:0] + 4'd1);
         2'd2: idx = 4'(4'd3 * r[3:0] + 4'd5);
         2'd3: idx = 4'(4'd7 * r[3:0]);
         default: idx = r[3:0];
      endcase
      return idx;
   endfunction

endpackage

`default_nettype wire

// ===== design/md5_round.sv =====
`default_nettype none

module md5_round (
   input  wire md5_pkg::md5_words_type words,
   input  wire logic [31:0]            w,
   input  wire logic [5:0]             rnd,
   output logic [31:0]                 new_b
);

   logic [31:0] mix;
   logic [31:0] sum;
   logic [31:0] rot;
   logic [4:0]  sh;

   always_comb begin
      case (rnd[5:4])
         2'd0: mix = (words.b & words.c) | (~words.b & words.d);
         2'd1: mix = (words.b & words.d) | (words.c & ~words.d);
         2'd2: mix = words.b ^ words.c ^ words.d;
         2'd3: mix = words.c ^ (words.b | ~words.d);
         default: mix = '0;
      endcase
   end

   assign sh    = md5_pkg::ROT_AMOUNT[{rnd[5:4], rnd[1:0]}];
   assign sum   = words.a + mix + md5_pkg::ROUND_CONST[rnd] + w;
   assign rot   = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
   assign new_b = words.b + rot;

endmodule

`default_nettype wire

// ===== design/md5_message_digest_core.sv =====
`default_nettype none

// channel   direction  ports                          payload
// req       in         req_valid req_stall            req_type, data_byte
// rsp       out        rsp_valid rsp_stall            digest_first_half, digest_second_half
//
// message bytes are accepted while the sequencer is idle; the 64th byte of a block
// starts the compression: one read prefetch, 64 rounds through the shared round adder,
// and one fold. end of message: padding, then the compression once or twice, and emit.
// req_stall is high whenever the sequencer is not idle.
// reset returns the chaining words and byte count to their initial values.
// the digest sits in an output register, so message bytes keep flowing while it waits.

module md5_message_digest_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire md5_pkg::md5_req_type req_payload,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output md5_pkg::md5_rsp_type      rsp_payload
);

   md5_pkg::md5_state_type state_ff, state_in;
   logic [63:0]            count_ff, count_in;
   md5_pkg::md5_words_type chain_ff, chain_in;
   md5_pkg::md5_words_type work_ff, work_in;
   logic [5:0]             rnd_ff, rnd_in;
   logic [3:0]             wi_ff, wi_in;
   logic [5:0]             lo_ff, lo_in;
   logic                   mark_ff, mark_in;
   logic                   len_ff, len_in;
   logic                   two_ff, two_in;
   logic                   fin_ff, fin_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   md5_pkg::md5_rsp_type   rsp_ff, rsp_in;

   logic [3:0][7:0]        mem [16];
   logic [31:0]            rd_ff;
   logic [3:0]             rd_addr;
   logic [3:0]             mem_waddr;
   logic [3:0]             mem_we;
   logic [3:0][7:0]        mem_wdata;

   logic [63:0]            bit_len;
   logic [31:0]            new_b;
   logic [5:0]             pos;

   assign bit_len = {count_ff[60:0], 3'b000};

   md5_round u_md5_round (
      .words (work_ff),
      .w     (rd_ff),
      .rnd   (rnd_ff),
      .new_b (new_b)
   );

   always_ff @(posedge clock) begin
      for (int j = 0; j < 4; j++) begin
         if (mem_we[j]) begin
            mem[mem_waddr][j] <= mem_wdata[j];
         end
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= md5_pkg::ST_IDLE;
         count_ff     <= '0;
         chain_ff     <= md5_pkg::CHAIN_INIT;
         two_ff       <= 1'b0;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chain_ff     <= chain_in;
         two_ff       <= two_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      work_ff <= work_in;
      rnd_ff  <= rnd_in;
      wi_ff   <= wi_in;
      lo_ff   <= lo_in;
      mark_ff <= mark_in;
      len_ff  <= len_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      chain_in     = chain_ff;
      work_in      = work_ff;
      rnd_in       = rnd_ff;
      wi_in        = wi_ff;
      lo_in        = lo_ff;
      mark_in      = mark_ff;
      len_in       = len_ff;
      two_in       = two_ff;
      fin_in       = fin_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      mem_we       = '0;
      mem_waddr    = wi_ff;
      mem_wdata    = '0;
      pos          = '0;
      rd_addr      = md5_pkg::word_index(6'(rnd_ff + 6'd1));

      case (state_ff)
         md5_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_payload.req_type == md5_pkg::REQ_BYTE) begin
                  mem_waddr = count_ff[5:2];
                  mem_we    = 4'b0001 << count_ff[1:0];
                  mem_wdata = {4{req_payload.data_byte}};
                  count_in  = count_ff + 64'd1;
                  if (count_ff[5:0] == md5_pkg::LAST_BYTE) begin
                     state_in = md5_pkg::ST_PREFETCH;
                  end
               end else begin
                  fin_in   = 1'b1;
                  lo_in    = count_ff[5:0];
                  mark_in  = 1'b1;
                  len_in   = count_ff[5:0] < md5_pkg::LEN_POS;
                  two_in   = !(count_ff[5:0] < md5_pkg::LEN_POS);
                  wi_in    = count_ff[5:2];
                  state_in = md5_pkg::ST_PAD;
               end
            end
         end
         md5_pkg::ST_PAD: begin
            // one buffer word per cycle, bytes below the fill level kept
            for (int j = 0; j < 4; j++) begin
               pos       = {wi_ff, 2'(j)};
               mem_we[j] = pos >= lo_ff;
               if (mark_ff && pos == lo_ff) begin
                  mem_wdata[j] = md5_pkg::PAD_MARK;
               end else if (len_ff && pos >= md5_pkg::LEN_POS) begin
                  mem_wdata[j] = bit_len[8 * pos[2:0] +: 8];
               end else begin
                  mem_wdata[j] = '0;
               end
            end
            if (wi_ff == md5_pkg::LAST_WORD) begin
               state_in = md5_pkg::ST_PREFETCH;
            end else begin
               wi_in = wi_ff + 4'd1;
            end
         end
         md5_pkg::ST_PREFETCH: begin
            rd_addr  = md5_pkg::word_index(6'd0);
            work_in  = chain_ff;
            rnd_in   = '0;
            state_in = md5_pkg::ST_ROUND;
         end
         md5_pkg::ST_ROUND: begin
            work_in.a = work_ff.d;
            work_in.b = new_b;
            work_in.c = work_ff.b;
            work_in.d = work_ff.c;
            rnd_in    = rnd_ff + 6'd1;
            if (rnd_ff == md5_pkg::LAST_ROUND) begin
               state_in = md5_pkg::ST_FOLD;
            end
         end
         md5_pkg::ST_FOLD: begin
            chain_in.a = chain_ff.a + work_ff.a;
            chain_in.b = chain_ff.b + work_ff.b;
            chain_in.c = chain_ff.c + work_ff.c;
            chain_in.d = chain_ff.d + work_ff.d;
            if (!fin_ff) begin
               state_in = md5_pkg::ST_IDLE;
            end else if (two_ff) begin
               // length goes into a second, otherwise empty block
               lo_in    = '0;
               mark_in  = 1'b0;
               len_in   = 1'b1;
               two_in   = 1'b0;
               wi_in    = '0;
               state_in = md5_pkg::ST_PAD;
            end else begin
               state_in = md5_pkg::ST_EMIT;
            end
         end
         md5_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                  = 1'b1;
               rsp_in.digest_first_half      = {chain_ff.b, chain_ff.a};
               rsp_in.digest_second_half     = {chain_ff.d, chain_ff.c};
               chain_in                      = md5_pkg::CHAIN_INIT;
               count_in                      = '0;
               fin_in                        = 1'b0;
               state_in                      = md5_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = md5_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_stall   = state_ff != md5_pkg::ST_IDLE;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ===== design/md5_checker.sv =====
`default_nettype none

module md5_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_stall,
   input wire md5_pkg::md5_req_type req_payload,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_stall,
   input wire md5_pkg::md5_rsp_type rsp_payload
);

   // no digest right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("digest word valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled digest word changed");

   // finishing a message always keeps the block busy for a while
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_payload.req_type == md5_pkg::REQ_END
      |=> req_stall ##1 req_stall)
      else $error("end of message accepted without finishing work");

   // a new digest is only loaded while the block is busy finishing
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("digest word appeared while idle");

   // a full block leaves the block busy for the compression
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_payload.req_type == md5_pkg::REQ_BYTE
      ##1 !req_stall ##1 req_stall
      |-> ##1 req_stall)
      else $error("compression ended too early");

endmodule

bind md5_message_digest_core md5_checker u_md5_checker (.*);

`default_nettype wire
